>>> design/rlec_pkg.sv
// ----------------------------------------------------------------------------
// rlec_pkg
// shared types and constants of the run-length escape byte compressor
// ----------------------------------------------------------------------------
`default_nettype none

package rlec_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'hFF;
  localparam logic [7:0] RUN_CAP    = 8'd255;
  localparam logic [7:0] MIN_TRIPLE = 8'd3;

  // one run to be flushed
  typedef struct packed {
    logic [7:0] run_byte;
    logic [7:0] run_len;
    logic       last;
  } cmd_t;

  // up to two flush commands from one input beat, in order
  typedef struct packed {
    logic valid0;
    logic valid1;
    cmd_t cmd0;
    cmd_t cmd1;
  } push_t;

endpackage

`default_nettype wire

>>> design/rlec_front.sv
// ----------------------------------------------------------------------------
// rlec_front
// run tracking: accepts data beats and emits flush commands
// ----------------------------------------------------------------------------
`default_nettype none

module rlec_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output rlec_pkg::push_t    push_cmds
);
  import rlec_pkg::*;

  logic [7:0] run_byte;
  logic [7:0] run_length;
  logic       run_open;
  logic [7:0] run_byte_next;
  logic [7:0] run_length_next;
  logic       run_open_next;

  logic       same;
  logic       flush_a;
  logic       flush_b;
  logic [7:0] grown_len;
  logic [7:0] grown_byte;
  cmd_t       cmd_a;
  cmd_t       cmd_b;

  always_comb begin
    same       = run_open && (in_byte == run_byte) && (run_length < RUN_CAP);
    flush_a    = run_open && !same;
    grown_len  = same ? (run_length + 8'd1) : 8'd1;
    grown_byte = same ? run_byte : in_byte;
    flush_b    = (grown_len == RUN_CAP) || in_last;

    cmd_a.run_byte = run_byte;
    cmd_a.run_len  = run_length;
    cmd_a.last     = 1'b0;
    cmd_b.run_byte = grown_byte;
    cmd_b.run_len  = grown_len;
    cmd_b.last     = in_last;

    push_cmds.valid0 = accept && (flush_a || flush_b);
    push_cmds.valid1 = accept && flush_a && flush_b;
    push_cmds.cmd0   = flush_a ? cmd_a : cmd_b;
    push_cmds.cmd1   = cmd_b;

    run_byte_next   = grown_byte;
    run_length_next = flush_b ? 8'd0 : grown_len;
    run_open_next   = !flush_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_byte   <= 8'd0;
      run_length <= 8'd0;
      run_open   <= 1'b0;
    end else if (accept) begin
      run_byte   <= run_byte_next;
      run_length <= run_length_next;
      run_open   <= run_open_next;
    end
  end

endmodule

`default_nettype wire

>>> design/rlec_cmd_queue.sv
// ----------------------------------------------------------------------------
// rlec_cmd_queue
// short command queue, two writes and one read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rlec_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rlec_pkg::push_t push_cmds,
  input  wire logic          pop,
  output logic               room2,
  output logic               head_valid,
  output rlec_pkg::cmd_t     head
);
  import rlec_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_p1;
  logic [PW-1:0] wr_ptr_p2;
  logic [PW-1:0] rd_ptr_next;
  logic [PW-1:0] wr_ptr_next;
  logic [CW-1:0] count_next;
  logic          pop_do;

  always_comb begin
    wr_ptr_p1   = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
    wr_ptr_p2   = (wr_ptr_p1 == LAST_PTR) ? '0 : wr_ptr_p1 + 1'b1;
    rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
    head_valid  = (count != '0);
    pop_do      = pop && head_valid;
    unique case ({push_cmds.valid0, push_cmds.valid1})
      2'b10:   wr_ptr_next = wr_ptr_p1;
      2'b11:   wr_ptr_next = wr_ptr_p2;
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CW'(push_cmds.valid0) + CW'(push_cmds.valid1) - CW'(pop_do);
    room2      = (count <= CW'(DEPTH - 2));
    head       = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push_cmds.valid0) begin
      mem[wr_ptr] <= push_cmds.cmd0;
    end
    if (push_cmds.valid1) begin
      mem[wr_ptr_p1] <= push_cmds.cmd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop_do) begin
        rd_ptr <= rd_ptr_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/rlec_back.sv
// ----------------------------------------------------------------------------
// rlec_back
// expands flush commands into output bytes, one beat per cycle unless pop stalls it
// ----------------------------------------------------------------------------
`default_nettype none

module rlec_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire rlec_pkg::cmd_t head,
  output logic               cmd_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import rlec_pkg::*;

  logic       out_valid;
  logic [1:0] step;
  logic [1:0] step_next;
  logic       is_triple;
  logic [1:0] final_step;
  logic       at_final;
  logic       advance;
  logic       load;
  logic [7:0] byte_next;
  logic       last_next;

  always_comb begin
    is_triple  = (head.run_len >= MIN_TRIPLE) || (head.run_byte == ESC_BYTE);
    final_step = is_triple ? 2'd2 : (head.run_len[1:0] - 2'd1);
    at_final   = (step == final_step);
    advance    = !out_valid || pop;
    load       = advance && head_valid;
    cmd_pop    = load && at_final;
    step_next  = at_final ? 2'd0 : (step + 2'd1);
    if (is_triple) begin
      unique case (step)
        2'd0:    byte_next = ESC_BYTE;
        2'd1:    byte_next = head.run_byte;
        default: byte_next = head.run_len;
      endcase
    end else begin
      byte_next = head.run_byte;
    end
    last_next = head.last && at_final;
    empty     = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 2'd0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_next;
      out_last <= last_next;
    end
  end

endmodule

`default_nettype wire

>>> design/rle_escape_byte_compressor.sv
// ----------------------------------------------------------------------------
// rle_escape_byte_compressor
// run-length compressor with escape byte 0xFF, one data byte per beat
// ----------------------------------------------------------------------------
// input side is a queue write port: a beat (in_byte, in_last) is taken when
// push is high and full is low. the result side is a queue read port: the
// oldest output byte sits on out_byte/out_last while empty is low and is
// taken when pop is high. a run of three or more, or any run of 0xFF, comes
// out as 0xFF, byte, count; a shorter run as one or two literal bytes.
// out_last marks the final byte of a message.
// an input beat is taken every cycle while the command queue has room for
// two flush commands. the first output byte of a flush passes through the
// command queue and then the output register. the output port moves one byte
// per cycle while pop is high, so throughput is set by the byte expander,
// which turns each flush command into one, two or three bytes.
// reset closes any open run and empties the queue and output register.
// when the receiver stalls the output byte holds, the command queue fills
// and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_escape_byte_compressor #(
  parameter int CMD_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import rlec_pkg::*;

  logic  accept;
  logic  room2;
  logic  head_valid;
  logic  cmd_pop;
  push_t push_cmds;
  cmd_t  head;

  assign full   = !room2;
  assign accept = push && room2;

  rlec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .push_cmds (push_cmds)
  );

  rlec_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmds  (push_cmds),
    .pop        (cmd_pop),
    .room2      (room2),
    .head_valid (head_valid),
    .head       (head)
  );

  rlec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

>>> sim/rle_out_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_out_checker
// watches both queue ports of the run-length escape byte compressor
// ----------------------------------------------------------------------------
// every input beat taken by the block is run through a local model of the
// run/flush rules; the compressed bytes it yields are queued in order. each
// output beat taken from the block is compared with the oldest queued byte,
// field by field. mismatches and output beats with nothing queued are
// counted and handed to the top, together with the number of bytes still owed.
// ----------------------------------------------------------------------------

module rle_out_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         owed_bytes
);
  import rlec_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } comp_beat_t;

  comp_beat_t compressed_q[$];

  logic [7:0] run_byte;
  logic [7:0] run_len;
  logic       run_open;

  function automatic void note_byte(input logic [7:0] data, input logic last);
    comp_beat_t b;
    b.data = data;
    b.last = last;
    compressed_q.push_back(b);
  endfunction

  // emit the held run; final byte carries mark_last
  function automatic void flush_run(input logic mark_last);
    int k;
    if (run_open && run_len != 8'd0) begin
      if (run_len >= MIN_TRIPLE || run_byte == ESC_BYTE) begin
        note_byte(ESC_BYTE, 1'b0);
        note_byte(run_byte, 1'b0);
        note_byte(run_len, mark_last);
      end else begin
        for (k = 0; k < int'(run_len); k++)
          note_byte(run_byte, mark_last && (k + 1 == int'(run_len)));
      end
    end
    run_open = 1'b0;
    run_len  = 8'd0;
  endfunction

  function automatic void compress_beat(input logic [7:0] data, input logic last);
    if (run_open && data == run_byte && run_len < RUN_CAP) begin
      run_len = run_len + 8'd1;
    end else begin
      if (run_open)
        flush_run(1'b0);
      run_byte = data;
      run_len  = 8'd1;
      run_open = 1'b1;
    end
    if (run_len >= RUN_CAP || last)
      flush_run(last);
  endfunction

  always @(posedge clk) begin
    comp_beat_t want;
    if (rst) begin
      run_byte = 8'd0;
      run_len  = 8'd0;
      run_open = 1'b0;
      compressed_q.delete();
      fail_count = 0;
      owed_bytes <= 0;
    end else begin
      if (pop && !empty) begin
        if (compressed_q.size() == 0) begin
          $error("unexpected out beat: out_byte %0h out_last %0b", out_byte, out_last);
          fail_count++;
        end else begin
          want = compressed_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (push && !full)
        compress_beat(in_byte, in_last);
      owed_bytes <= compressed_q.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the run-length escape byte compressor
// ----------------------------------------------------------------------------
// a short directed set covers one-byte messages, zero and escape bytes,
// literal and triple runs; then a run past the length cap, and random messages
// built from runs of mixed length plus noise. the sender works in bursts
// with gaps and now and then waits until all output has drained; the
// receiver stalls in changing patterns. a watchdog ends a stuck run.
// ----------------------------------------------------------------------------

module tb;
  import rlec_pkg::*;

  localparam int RANDOM_BEATS = 200;
  localparam int STALL_LIMIT  = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       in_last = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last;
  int         fail_count;
  int         owed_bytes;

  int beats_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int pop_style = 0;
  int pop_phase_left = 0;
  int pop_hold_left = 0;
  bit pop_level = 1'b1;

  always #5 clk = ~clk;

  rle_escape_byte_compressor dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  rle_out_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .fail_count (fail_count),
    .owed_bytes (owed_bytes)
  );

  // receiver: always ready, coin flips, or long on/off stretches
  always @(posedge clk) begin
    if (pop_phase_left == 0) begin
      pop_style = $urandom_range(0, 2);
      pop_phase_left = $urandom_range(50, 300);
    end
    pop_phase_left--;
    if (pop_hold_left == 0) begin
      case (pop_style)
        0: begin
          pop_level = 1'b1;
          pop_hold_left = 1;
        end
        1: begin
          pop_level = 1'($urandom_range(0, 1));
          pop_hold_left = 1;
        end
        default: begin
          pop_level = !pop_level;
          pop_hold_left = pop_level ? $urandom_range(1, 8) : $urandom_range(1, 16);
        end
      endcase
    end
    pop_hold_left--;
    pop <= pop_level;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("rle_escape_byte_compressor test failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] data, input logic last);
    int gap;
    push <= 1'b1;
    in_byte <= data;
    in_last <= last;
    do @(posedge clk); while (full);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_run(input logic [7:0] data, input int n, input logic last);
    for (int i = 0; i < n; i++)
      send_beat(data, last && (i == n - 1));
  endtask

  // hold the sender until every owed byte has come out
  task automatic drain;
    push <= 1'b0;
    do @(posedge clk); while (owed_bytes != 0);
  endtask

  function automatic logic [7:0] pick_byte;
    case ($urandom_range(0, 3))
      0: return ESC_BYTE;
      1: return 8'($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_len;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(1, 2);
    if (r < 9) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  initial begin
    int start;
    int nruns;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_run(8'h00, 1, 1'b1);
    send_run(ESC_BYTE, 1, 1'b1);
    send_run(8'h41, 2, 1'b0);
    send_run(8'h42, 1, 1'b1);
    send_run(ESC_BYTE, 2, 1'b0);
    send_run(8'h01, 1, 1'b1);
    send_run(8'h7E, 3, 1'b1);
    send_run(8'h80, 1, 1'b0);
    send_run(8'h01, 1, 1'b0);
    send_run(8'hFE, 1, 1'b0);
    send_run(8'h7F, 1, 1'b1);
    send_run(8'h55, 2, 1'b1);
    send_run(8'hAA, 4, 1'b1);
    drain();

    // run one past the cap: flush at the cap, then a new run with the last mark
    send_run(pick_byte(), 256, 1'b1);
    drain();

    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
          send_beat(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 3) == 0));
      end else begin
        nruns = $urandom_range(1, 6);
        for (int r = 0; r < nruns; r++)
          send_run(pick_byte(), pick_len(), r == nruns - 1);
      end
      if ($urandom_range(0, 29) == 0)
        drain();
    end

    drain();
    repeat (16) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("rle_escape_byte_compressor test passed");
    end else begin
      $display("rle_escape_byte_compressor test failed");
    end
    $finish;
  end

endmodule
